[sv/sdf_pkg.sv]
package sdf_pkg;

    // field and datapath widths
    localparam int InW     = 88;
    localparam int UserW   = 2;
    localparam int OutW    = 24;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 23;
    localparam int DistW   = 24;
    localparam int TgtW    = 23;
    localparam int VelW    = 23;
    localparam int CoefW   = 16;
    localparam int DtW     = 16;
    localparam int McandW  = 41;
    localparam int ProdW   = McandW + CoefW;
    localparam int PaW     = DistW + CoefW;
    localparam int CntW    = $clog2(CoefW);

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_SPRING = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DAMP   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_VLIM   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_TOL    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MIN    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_MAX    = 3'd5;

    // register defaults
    localparam logic [CoefW-1:0] RST_SPRING = 16'd12544;
    localparam logic [CoefW-1:0] RST_DAMP   = 16'd768;
    localparam logic [VelW-1:0]  RST_VLIM   = 23'd768000;
    localparam logic [TgtW-1:0]  RST_TOL    = 23'd256;
    localparam logic [TgtW-1:0]  RST_MIN    = 23'd61440;
    localparam logic [TgtW-1:0]  RST_MAX    = 23'd215040;

    localparam logic signed [DistW:0]   JUMP_LIMIT = 25'sd512;
    localparam logic [TgtW-1:0]         START_DIST = 23'd204800;
    localparam logic [VelW-1:0]         VEL_FLOOR  = 23'd26;
    localparam logic signed [DistW+1:0] DIST_HI    = 26'sd8388607;
    localparam logic signed [DistW+1:0] DIST_LO    = -26'sd8388608;

    typedef enum logic [1:0] {
        MUL_GS = 2'd0,   // gap * spring
        MUL_DV = 2'd1,   // damping * velocity
        MUL_AD = 2'd2,   // accel * frame time
        MUL_VD = 2'd3    // velocity * frame time
    } t_mul_op;

    typedef struct packed {
        logic    capture;
        logic    jump;
        logic    target;
        logic    clamp;
        logic    gap;
        logic    mul_start;
        t_mul_op mul_op;
        logic    save_pa;
        logic    vel;
        logic    move;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic settled;
        logic mul_done;
        logic out_full;
    } t_sts;

    // low bound wins first, then high bound
    function automatic logic [TgtW-1:0] clamp_u(input logic [TgtW-1:0] v,
                                                input logic [TgtW-1:0] lo,
                                                input logic [TgtW-1:0] hi);
        logic [TgtW-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/spring_damped_distance_follower_core.sv]
// The spring step runs only when the gap exceeds the tolerance; otherwise the distance
// snaps to the target, and when object or boundary is absent the result is zero.
// A new item is taken only after the last result is loaded into the output register;
// the spring step is set by four shift-add multiplies sharing one serial multiplier.
// A finished result waits in the output register while the next item is taken.
// Reset (i_rst_n low, synchronous) clears follower state and restores register defaults.
module spring_damped_distance_follower_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sdf_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [sdf_pkg::CfgW-1:0]     i_cfg_wdata,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // player_present, bounds_present, reference_height, ceiling_height,
    // frame_time, new_target
    input  logic [sdf_pkg::InW-1:0]      i_s_axis_tdata,
    // ceiling_valid, target_load
    input  logic [sdf_pkg::UserW-1:0]    i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // current_distance
    output logic [sdf_pkg::OutW-1:0]     o_m_axis_tdata
);
    import sdf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sdf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

[sv/sdf_mul.sv]
module sdf_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [sdf_pkg::McandW-1:0]      i_mcand,
    input  logic        [sdf_pkg::CoefW-1:0]       i_mplr,
    output logic                                   o_done,
    output logic signed [sdf_pkg::ProdW-1:0]       o_prod
);
    import sdf_pkg::*;

    logic                    r_busy;
    logic [CntW-1:0]         r_cnt;
    logic signed [ProdW-1:0] r_mc;
    logic [CoefW-1:0]        r_mp;
    logic signed [ProdW-1:0] r_acc;

    assign o_done = r_busy && (r_cnt == CntW'(CoefW - 1));
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // one multiplier bit per cycle, lsb first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc  <= ProdW'(i_mcand);
            r_mp  <= i_mplr;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_mp[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= r_mc <<< 1;
            r_mp <= r_mp >> 1;
        end
    end

endmodule

[sv/sdf_datapath.sv]
module sdf_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sdf_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [sdf_pkg::CfgW-1:0]          i_cfg_wdata,
    input  logic [sdf_pkg::InW-1:0]           i_s_tdata,
    input  logic [sdf_pkg::UserW-1:0]         i_s_tuser,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [sdf_pkg::OutW-1:0]          o_m_tdata,
    input  sdf_pkg::t_cmd                     i_cmd,
    output sdf_pkg::t_sts                     o_sts
);
    import sdf_pkg::*;

    // configuration
    logic [CoefW-1:0] r_spring, r_damp;
    logic [VelW-1:0]  r_vlim;
    logic [TgtW-1:0]  r_tol, r_min, r_max;

    // captured item
    logic                    r_active;
    logic signed [DistW-1:0] r_height;
    logic                    r_ceil_ok;
    logic [TgtW-1:0]         r_ceil;
    logic [DtW-1:0]          r_dt;
    logic                    r_load;
    logic [TgtW-1:0]         r_req;

    // follower state
    logic signed [DistW-1:0] r_cur;
    logic [TgtW-1:0]         r_tgt;
    logic                    r_tset;
    logic [VelW-1:0]         r_vel;
    logic signed [DistW-1:0] r_last;
    logic                    r_last_ok;

    // working registers
    logic [DistW-1:0] r_gap;
    logic             r_up;
    logic [PaW-1:0]   r_pa;
    logic             r_m_tvalid;
    logic [OutW-1:0]  r_m_tdata;

    logic signed [McandW-1:0] mul_mcand;
    logic [CoefW-1:0]         mul_mplr;
    logic                     mul_done;
    logic signed [ProdW-1:0]  prod;

    logic [TgtW-1:0]           hi_lim, first_tgt, first_cur, clamp_tgt;
    logic signed [DistW:0]     h_diff, g_diff, g_neg, n_up, n_dn, tgt_ext;
    logic                      jump;
    logic signed [DistW+1:0]   cur_sh;
    logic signed [DistW-1:0]   cur_sat, cur_mv;
    logic [DistW-1:0]          gap_abs;
    logic                      settled;
    logic signed [McandW-1:0]  accel;
    logic signed [VelW+10:0]   v_sum, vlim_s;
    logic [VelW-1:0]           v_new;
    logic [VelW-1:0]           step;

    sdf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_mcand (mul_mcand),
        .i_mplr  (mul_mplr),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    always_comb begin
        hi_lim = (r_ceil_ok && (r_ceil < r_max)) ? r_ceil : r_max;

        // height jump shifts the distance the other way
        h_diff  = $signed({r_height[DistW-1], r_height}) - $signed({r_last[DistW-1], r_last});
        jump    = r_last_ok && ((h_diff > JUMP_LIMIT) || (h_diff < -JUMP_LIMIT));
        cur_sh  = $signed({{2{r_cur[DistW-1]}}, r_cur}) - $signed({h_diff[DistW], h_diff});
        if (cur_sh > DIST_HI) begin
            cur_sat = DIST_HI[DistW-1:0];
        end else if (cur_sh < DIST_LO) begin
            cur_sat = DIST_LO[DistW-1:0];
        end else begin
            cur_sat = cur_sh[DistW-1:0];
        end

        first_tgt = clamp_u(START_DIST, r_min, hi_lim);
        first_cur = r_ceil_ok ? clamp_u(first_tgt, r_min, r_ceil) : first_tgt;
        clamp_tgt = clamp_u(r_tgt, r_min, hi_lim);

        g_diff  = $signed({2'b00, r_tgt}) - $signed({r_cur[DistW-1], r_cur});
        g_neg   = -g_diff;
        gap_abs = g_diff[DistW] ? g_neg[DistW-1:0] : g_diff[DistW-1:0];
        settled = gap_abs <= {1'b0, r_tol};

        accel = $signed({1'b0, r_pa}) - $signed({2'b00, prod[VelW+CoefW-1:0]});

        case (i_cmd.mul_op)
            MUL_GS: begin
                mul_mcand = $signed({{(McandW-DistW){1'b0}}, r_gap});
                mul_mplr  = r_spring;
            end
            MUL_DV: begin
                mul_mcand = $signed({{(McandW-VelW){1'b0}}, r_vel});
                mul_mplr  = r_damp;
            end
            MUL_AD: begin
                mul_mcand = accel;
                mul_mplr  = r_dt;
            end
            MUL_VD: begin
                mul_mcand = $signed({{(McandW-VelW){1'b0}}, r_vel});
                mul_mplr  = r_dt;
            end
            default: begin
                mul_mcand = '0;
                mul_mplr  = '0;
            end
        endcase

        // velocity += floor(accel*dt / 2^24), clamped to [floor, limit]
        v_sum  = $signed({11'b0, r_vel}) + $signed({prod[ProdW-1], prod[ProdW-1:24]});
        vlim_s = $signed({11'b0, r_vlim});
        if (v_sum < $signed({11'b0, VEL_FLOOR})) begin
            v_new = VEL_FLOOR;
        end else if (v_sum > vlim_s) begin
            v_new = r_vlim;
        end else begin
            v_new = v_sum[VelW-1:0];
        end

        // step toward target, never past it
        step    = prod[VelW+DtW-1:DtW];
        tgt_ext = $signed({2'b00, r_tgt});
        n_up    = $signed({r_cur[DistW-1], r_cur}) + $signed({2'b00, step});
        n_dn    = $signed({r_cur[DistW-1], r_cur}) - $signed({2'b00, step});
        if (r_up) begin
            cur_mv = (n_up < tgt_ext) ? n_up[DistW-1:0] : $signed({1'b0, r_tgt});
        end else begin
            cur_mv = (n_dn > tgt_ext) ? n_dn[DistW-1:0] : $signed({1'b0, r_tgt});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spring   <= RST_SPRING;
            r_damp     <= RST_DAMP;
            r_vlim     <= RST_VLIM;
            r_tol      <= RST_TOL;
            r_min      <= RST_MIN;
            r_max      <= RST_MAX;
            r_cur      <= '0;
            r_tgt      <= '0;
            r_tset     <= 1'b0;
            r_vel      <= '0;
            r_last     <= '0;
            r_last_ok  <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SPRING: r_spring <= i_cfg_wdata[CoefW-1:0];
                    CFG_DAMP:   r_damp   <= i_cfg_wdata[CoefW-1:0];
                    CFG_VLIM:   r_vlim   <= i_cfg_wdata[VelW-1:0];
                    CFG_TOL:    r_tol    <= i_cfg_wdata[TgtW-1:0];
                    CFG_MIN:    r_min    <= i_cfg_wdata[TgtW-1:0];
                    CFG_MAX:    r_max    <= i_cfg_wdata[TgtW-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.jump) begin
                r_last    <= r_height;
                r_last_ok <= 1'b1;
                if (jump) begin
                    r_cur <= cur_sat;
                end
            end

            if (i_cmd.target) begin
                if (r_load) begin
                    r_tgt  <= r_req;
                    r_tset <= 1'b1;
                end else if (!r_tset) begin
                    r_tgt  <= first_tgt;
                    r_cur  <= $signed({1'b0, first_cur});
                    r_tset <= 1'b1;
                end
            end

            if (i_cmd.clamp && r_ceil_ok) begin
                r_tgt <= clamp_tgt;
            end

            if (i_cmd.gap && settled) begin
                r_vel <= '0;
                r_cur <= $signed({1'b0, r_tgt});
            end

            if (i_cmd.vel) begin
                r_vel <= v_new;
            end

            if (i_cmd.move) begin
                r_cur <= cur_mv;
            end

            if (i_cmd.out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_active  <= i_s_tdata[0] & i_s_tdata[1];
            r_height  <= $signed(i_s_tdata[25:2]);
            r_ceil    <= i_s_tdata[48:26];
            r_dt      <= i_s_tdata[64:49];
            r_req     <= i_s_tdata[87:65];
            r_ceil_ok <= i_s_tuser[0];
            r_load    <= i_s_tuser[1];
        end
        if (i_cmd.gap) begin
            r_gap <= gap_abs;
            r_up  <= !g_diff[DistW];
        end
        if (i_cmd.save_pa) begin
            r_pa <= prod[PaW-1:0];
        end
        if (i_cmd.out_load) begin
            r_m_tdata <= r_active ? r_cur : '0;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    assign o_sts.active   = r_active;
    assign o_sts.settled  = settled;
    assign o_sts.mul_done = mul_done;
    assign o_sts.out_full = r_m_tvalid && !i_m_tready;

endmodule

[sv/sdf_ctrl.sv]
module sdf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  sdf_pkg::t_sts  i_sts,
    output sdf_pkg::t_cmd  o_cmd
);
    import sdf_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_JUMP = 16'h0002,
        S_TGT  = 16'h0004,
        S_CLMP = 16'h0008,
        S_GAP  = 16'h0010,
        S_SGS  = 16'h0020,
        S_MGS  = 16'h0040,
        S_SDV  = 16'h0080,
        S_MDV  = 16'h0100,
        S_SAD  = 16'h0200,
        S_MAD  = 16'h0400,
        S_VEL  = 16'h0800,
        S_SVD  = 16'h1000,
        S_MVD  = 16'h2000,
        S_MOVE = 16'h4000,
        S_OUT  = 16'h8000
    } t_state;

    t_state r_state, n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_op = MUL_GS;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_JUMP;
                end
            end
            S_JUMP: begin
                if (i_sts.active) begin
                    o_cmd.jump = 1'b1;
                    n_state = S_TGT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_TGT: begin
                o_cmd.target = 1'b1;
                n_state = S_CLMP;
            end
            S_CLMP: begin
                o_cmd.clamp = 1'b1;
                n_state = S_GAP;
            end
            S_GAP: begin
                o_cmd.gap = 1'b1;
                n_state = i_sts.settled ? S_OUT : S_SGS;
            end
            S_SGS: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_GS;
                n_state = S_MGS;
            end
            S_MGS: begin
                if (i_sts.mul_done) begin
                    n_state = S_SDV;
                end
            end
            S_SDV: begin
                // spring term is kept while the damping product runs
                o_cmd.save_pa   = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_DV;
                n_state = S_MDV;
            end
            S_MDV: begin
                if (i_sts.mul_done) begin
                    n_state = S_SAD;
                end
            end
            S_SAD: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_AD;
                n_state = S_MAD;
            end
            S_MAD: begin
                if (i_sts.mul_done) begin
                    n_state = S_VEL;
                end
            end
            S_VEL: begin
                o_cmd.vel = 1'b1;
                n_state = S_SVD;
            end
            S_SVD: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = MUL_VD;
                n_state = S_MVD;
            end
            S_MVD: begin
                if (i_sts.mul_done) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sim/tb_spring_damped_distance_follower_core.sv]
module tb_spring_damped_distance_follower_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASES        = 6;
    localparam int ITEMS_PER_PH  = 300;

    localparam longint JUMP_MAX   = 512;
    localparam longint HOME_DIST  = 204800;
    localparam longint MIN_SPEED  = 26;
    localparam longint DIST_TOP   = 8388607;
    localparam longint DIST_FLOOR = -8388608;

    typedef struct {
        logic               player;
        logic               bounds;
        logic signed [23:0] height;
        logic               ceil_ok;
        logic [22:0]        ceil_h;
        logic [15:0]        dt;
        logic               load;
        logic [22:0]        req;
    } t_frame_tick;

    // directed vectors: fixed is 1 where the distance is known without the predictor
    typedef struct {
        int player;
        int bounds;
        int height;
        int ceil_ok;
        int ceil_h;
        int dt;
        int load;
        int req;
        int fixed;
        int want_dist;
    } t_vector_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic [sdf_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [sdf_pkg::CfgW-1:0]    cfg_wdata = '0;
    logic                        s_valid = 1'b0;
    logic [sdf_pkg::InW-1:0]     s_data = '0;
    logic [sdf_pkg::UserW-1:0]   s_user = '0;
    logic                        s_ready;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [sdf_pkg::OutW-1:0]    m_data;

    // follower copy: settings and state
    logic [15:0] spring_k  = sdf_pkg::RST_SPRING;
    logic [15:0] damp_k    = sdf_pkg::RST_DAMP;
    logic [22:0] speed_cap = sdf_pkg::RST_VLIM;
    logic [22:0] snap_tol  = sdf_pkg::RST_TOL;
    logic [22:0] dist_lo   = sdf_pkg::RST_MIN;
    logic [22:0] dist_hi   = sdf_pkg::RST_MAX;
    longint      cur_dist = 0;
    longint      tgt_dist = 0;
    longint      speed = 0;
    longint      prev_height = 0;
    bit          tgt_valid = 1'b0;
    bit          prev_valid = 1'b0;

    logic [23:0] dist_expected_q[$];
    int          mismatch_count = 0;
    int          src_idle_pct = 33;
    int          snk_idle_pct = 86;
    int          walk_height = 0;

    spring_damped_distance_follower_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever begin
            #HALF_PERIOD i_clk = ~i_clk;
        end
    end

    function automatic longint sat_dist(input longint v);
        if (v > DIST_TOP) begin
            return DIST_TOP;
        end
        if (v < DIST_FLOOR) begin
            return DIST_FLOOR;
        end
        return v;
    endfunction

    // low bound checked first, so lo > hi leaves anything above lo at hi
    function automatic longint bound_to(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [23:0] predict_distance(input t_frame_tick t);
        longint h;
        longint ch;
        longint lo;
        longint hi;
        longint dtl;
        longint diff;
        longint gap;
        longint accel;
        longint v;
        longint stride;
        longint nxt;
        if (!t.player || !t.bounds) begin
            return '0;
        end
        h   = longint'(t.height);
        ch  = longint'(t.ceil_h);
        lo  = longint'(dist_lo);
        hi  = longint'(dist_hi);
        dtl = longint'(t.dt);

        if (prev_valid) begin
            diff = h - prev_height;
            if (diff > JUMP_MAX || diff < -JUMP_MAX) begin
                cur_dist = sat_dist(cur_dist - diff);
            end
        end
        prev_height = h;
        prev_valid  = 1'b1;

        if (t.load) begin
            tgt_dist  = longint'(t.req);
            tgt_valid = 1'b1;
        end
        if (t.ceil_ok && ch < hi) begin
            hi = ch;
        end
        if (!tgt_valid) begin
            tgt_dist = bound_to(HOME_DIST, lo, hi);
            cur_dist = tgt_dist;
            if (t.ceil_ok) begin
                cur_dist = bound_to(cur_dist, lo, ch);
            end
            tgt_valid = 1'b1;
        end
        if (t.ceil_ok) begin
            tgt_dist = bound_to(tgt_dist, lo, hi);
        end

        gap = tgt_dist - cur_dist;
        if (gap < 0) begin
            gap = -gap;
        end
        if (gap > longint'(snap_tol)) begin
            accel  = gap * longint'(spring_k) - longint'(damp_k) * speed;
            v      = speed + ((accel * dtl) >>> 24);
            v      = bound_to(v, MIN_SPEED, longint'(speed_cap));
            speed  = v;
            stride = (v * dtl) >>> 16;
            if (cur_dist < tgt_dist) begin
                nxt = cur_dist + stride;
                cur_dist = (nxt < tgt_dist) ? nxt : tgt_dist;
            end else begin
                nxt = cur_dist - stride;
                cur_dist = (nxt > tgt_dist) ? nxt : tgt_dist;
            end
        end else begin
            speed    = 0;
            cur_dist = tgt_dist;
        end
        cur_dist = sat_dist(cur_dist);
        return cur_dist[23:0];
    endfunction

    function automatic t_frame_tick random_tick();
        t_frame_tick t;
        logic [31:0] r;
        int          m;
        t.player = ($urandom_range(19) != 0);
        t.bounds = ($urandom_range(19) != 0);
        r = $urandom();
        case ($urandom_range(9))
            0: begin
                walk_height = $signed(r[23:0]);
            end
            1: begin
                case ($urandom_range(2))
                    0: m = 512;
                    1: m = 513;
                    default: m = int'($urandom_range(200000, 514));
                endcase
                walk_height = ($urandom_range(1) != 0) ? walk_height + m : walk_height - m;
            end
            default: begin
                walk_height = walk_height + int'($urandom_range(600)) - 300;
            end
        endcase
        t.height = walk_height[23:0];

        t.ceil_ok = ($urandom_range(1) != 0);
        r = $urandom();
        case ($urandom_range(5))
            0: t.ceil_h = r[22:0];
            1: t.ceil_h = ($urandom_range(1) != 0) ? '1 : '0;
            default: begin
                r = $urandom_range(300000, 40000);
                t.ceil_h = r[22:0];
            end
        endcase

        r = $urandom();
        case ($urandom_range(9))
            0: t.dt = '0;
            1: t.dt = '1;
            2: t.dt = r[15:0];
            default: begin
                r = $urandom_range(2200, 800);
                t.dt = r[15:0];
            end
        endcase

        t.load = ($urandom_range(9) == 0);
        r = ($urandom_range(1) != 0) ? $urandom() : $urandom_range(400000);
        t.req = r[22:0];
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ERROR: %s", $time, msg);
    endtask

    // called at a falling edge; returns at the falling edge after the write
    task automatic write_reg(input logic [sdf_pkg::CfgIdxW-1:0] idx, input logic [22:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            sdf_pkg::CFG_SPRING: spring_k  = val[15:0];
            sdf_pkg::CFG_DAMP:   damp_k    = val[15:0];
            sdf_pkg::CFG_VLIM:   speed_cap = val;
            sdf_pkg::CFG_TOL:    snap_tol  = val;
            sdf_pkg::CFG_MIN:    dist_lo   = val;
            sdf_pkg::CFG_MAX:    dist_hi   = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input int ph);
        logic [31:0] r [6];
        foreach (r[k]) begin
            r[k] = $urandom();
        end
        case (ph)
            0: begin
                write_reg(sdf_pkg::CFG_SPRING, 23'(sdf_pkg::RST_SPRING));
                write_reg(sdf_pkg::CFG_DAMP,   23'(sdf_pkg::RST_DAMP));
                write_reg(sdf_pkg::CFG_VLIM,   sdf_pkg::RST_VLIM);
                write_reg(sdf_pkg::CFG_TOL,    sdf_pkg::RST_TOL);
                write_reg(sdf_pkg::CFG_MIN,    sdf_pkg::RST_MIN);
                write_reg(sdf_pkg::CFG_MAX,    sdf_pkg::RST_MAX);
            end
            1: begin
                // stiffest spring, no damping, widest range
                write_reg(sdf_pkg::CFG_SPRING, 23'd65535);
                write_reg(sdf_pkg::CFG_DAMP,   23'd0);
                write_reg(sdf_pkg::CFG_VLIM,   23'd8388607);
                write_reg(sdf_pkg::CFG_TOL,    23'd0);
                write_reg(sdf_pkg::CFG_MIN,    23'd0);
                write_reg(sdf_pkg::CFG_MAX,    23'd8388607);
            end
            2: begin
                // crawl speed, min above max
                write_reg(sdf_pkg::CFG_SPRING, 23'd0);
                write_reg(sdf_pkg::CFG_DAMP,   23'd65535);
                write_reg(sdf_pkg::CFG_VLIM,   23'd26);
                write_reg(sdf_pkg::CFG_TOL,    23'd0);
                write_reg(sdf_pkg::CFG_MIN,    23'd100000);
                write_reg(sdf_pkg::CFG_MAX,    23'd50000);
            end
            4: begin
                // everything snaps, range pinned at the top
                write_reg(sdf_pkg::CFG_SPRING, 23'(r[0][15:0]));
                write_reg(sdf_pkg::CFG_DAMP,   23'(r[1][15:0]));
                write_reg(sdf_pkg::CFG_VLIM,   23'($urandom_range(8388607, 26)));
                write_reg(sdf_pkg::CFG_TOL,    23'd8388607);
                write_reg(sdf_pkg::CFG_MIN,    23'd8388607);
                write_reg(sdf_pkg::CFG_MAX,    23'd8388607);
            end
            default: begin
                write_reg(sdf_pkg::CFG_SPRING, 23'(r[0][15:0]));
                write_reg(sdf_pkg::CFG_DAMP,   23'($urandom_range(4096)));
                write_reg(sdf_pkg::CFG_VLIM,   23'($urandom_range(2000000, 26)));
                write_reg(sdf_pkg::CFG_TOL,    23'($urandom_range(2048)));
                write_reg(sdf_pkg::CFG_MIN,    23'($urandom_range(200000)));
                write_reg(sdf_pkg::CFG_MAX,    23'($urandom_range(400000)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    // drops valid, waits out all results, then lets the datapath go quiet
    task automatic wait_quiet();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (dist_expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_tick(input t_frame_tick t, input bit fixed, input logic [23:0] fixed_dist);
        logic [23:0] predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {t.req, t.dt, t.ceil_h, t.height, t.bounds, t.player};
        s_user  <= {t.load, t.ceil_ok};
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        predicted = predict_distance(t);
        dist_expected_q.push_back(fixed ? fixed_dist : predicted);
    endtask

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        logic [23:0] want;
        if (i_rst_n && m_valid && m_ready) begin
            if (dist_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result distance=%0d", $signed(m_data)));
            end else begin
                want = dist_expected_q.pop_front();
                if (m_data !== want) begin
                    report_mismatch($sformatf("current_distance got %0d expected %0d",
                                              $signed(m_data), $signed(want)));
                end
            end
        end
    end

    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        t_vector_row vectors[];
        t_frame_tick t;
        int          active_sent;
        vectors = '{
            '{0, 1, 0,        0, 0,       1092,  0, 0,       1, 0},
            '{1, 0, 0,        0, 0,       1092,  0, 0,       1, 0},
            // first active tick with the ceiling under the floor
            '{1, 1, 0,        1, 30000,   1092,  0, 0,       1, 61440},
            '{1, 1, 0,        1, 8388607, 65535, 1, 8388607, 0, 0},
            '{1, 1, 0,        0, 0,       65535, 0, 0,       0, 0},
            '{1, 1, 513,      0, 0,       1092,  0, 0,       0, 0},
            '{1, 1, 1025,     0, 0,       1092,  0, 0,       0, 0},
            '{1, 1, -8388608, 0, 0,       1092,  0, 0,       0, 0},
            '{1, 1, 8388607,  0, 0,       1092,  0, 0,       0, 0},
            '{1, 1, 8388607,  0, 0,       0,     0, 0,       0, 0},
            '{1, 1, 8388607,  1, 0,       1092,  1, 0,       0, 0},
            '{0, 0, -1,       1, 8388607, 65535, 1, 8388607, 1, 0},
            '{1, 1, 8388607,  0, 0,       65535, 1, 100000,  0, 0},
            '{1, 1, 8388607,  0, 0,       65535, 0, 0,       0, 0},
            '{1, 1, 8388607,  0, 0,       65535, 0, 0,       0, 0},
            '{1, 1, 8388607,  0, 0,       65535, 0, 0,       0, 0},
            '{1, 1, 8388607,  0, 0,       65535, 0, 0,       0, 0},
            '{1, 1, 8388400,  1, 150000,  1092,  0, 0,       0, 0},
            '{1, 1, 8388300,  1, 150000,  1092,  1, 140000,  0, 0},
            '{1, 1, 8388300,  1, 150000,  65535, 0, 0,       0, 0},
            '{1, 1, 8388300,  1, 150000,  65535, 0, 0,       0, 0},
            '{1, 1, 8388300,  0, 0,       1092,  0, 0,       0, 0}
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        apply_settings(0);

        foreach (vectors[k]) begin
            t.player  = vectors[k].player[0];
            t.bounds  = vectors[k].bounds[0];
            t.height  = vectors[k].height[23:0];
            t.ceil_ok = vectors[k].ceil_ok[0];
            t.ceil_h  = vectors[k].ceil_h[22:0];
            t.dt      = vectors[k].dt[15:0];
            t.load    = vectors[k].load[0];
            t.req     = vectors[k].req[22:0];
            send_tick(t, vectors[k].fixed != 0, vectors[k].want_dist[23:0]);
        end
        walk_height = 8388300;

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_quiet();
                apply_settings(ph);
            end
            case (ph / 2)
                0: begin
                    src_idle_pct = 33;
                    snk_idle_pct = 86;
                end
                1: begin
                    src_idle_pct = 86;
                    snk_idle_pct = 33;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            active_sent = 0;
            while (active_sent < ITEMS_PER_PH) begin
                t = random_tick();
                if (t.player && t.bounds) begin
                    active_sent++;
                end
                send_tick(t, 1'b0, '0);
            end
        end

        wait_quiet();
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
sv/sdf_pkg.sv
sv/sdf_mul.sv
sv/sdf_datapath.sv
sv/sdf_ctrl.sv
sv/spring_damped_distance_follower_core.sv
sim/tb_spring_damped_distance_follower_core.sv
